// ===== rtl/crw_pkg.sv =====
// Shared constants, command/status types and step codes for the spline weight block.
// No dependencies; the top level, crw_ctrl and crw_datapath import this package.
`timescale 1ns / 1ps

package crw_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int NCW        = 7;   // node_count register width
    localparam int IDXW       = 6;   // node_index field width
    localparam int NODEW      = 32;  // node_value / query_x width
    localparam int OFSW       = 7;   // base_offset width
    localparam int IN_TDATA_W = 72;  // 6 + 32 + 32 rounded up to bytes
    localparam int OPW        = 5;

    localparam logic [NCW-1:0] NODE_COUNT_RST = NCW'(64);

    // Step codes; the controller state carries the step it is issuing.
    localparam logic [OPW-1:0] OP_IDLE  = 5'd0;
    localparam logic [OPW-1:0] OP_RD_LO = 5'd1;
    localparam logic [OPW-1:0] OP_RD_HI = 5'd2;
    localparam logic [OPW-1:0] OP_CHK   = 5'd3;
    localparam logic [OPW-1:0] OP_SRD   = 5'd4;
    localparam logic [OPW-1:0] OP_SUPD  = 5'd5;
    localparam logic [OPW-1:0] OP_IDX   = 5'd6;
    localparam logic [OPW-1:0] OP_RX0   = 5'd7;
    localparam logic [OPW-1:0] OP_RX1   = 5'd8;
    localparam logic [OPW-1:0] OP_RXM   = 5'd9;
    localparam logic [OPW-1:0] OP_RXP   = 5'd10;
    localparam logic [OPW-1:0] OP_CXP   = 5'd11;
    localparam logic [OPW-1:0] OP_DX    = 5'd12;
    localparam logic [OPW-1:0] OP_TDIV  = 5'd13;
    localparam logic [OPW-1:0] OP_TWAIT = 5'd14;
    localparam logic [OPW-1:0] OP_T     = 5'd15;
    localparam logic [OPW-1:0] OP_T2    = 5'd16;
    localparam logic [OPW-1:0] OP_T3    = 5'd17;
    localparam logic [OPW-1:0] OP_H     = 5'd18;
    localparam logic [OPW-1:0] OP_MULM  = 5'd19;
    localparam logic [OPW-1:0] OP_DIVM  = 5'd20;
    localparam logic [OPW-1:0] OP_MWAIT = 5'd21;
    localparam logic [OPW-1:0] OP_SM    = 5'd22;
    localparam logic [OPW-1:0] OP_MULP  = 5'd23;
    localparam logic [OPW-1:0] OP_DIVP  = 5'd24;
    localparam logic [OPW-1:0] OP_PWAIT = 5'd25;
    localparam logic [OPW-1:0] OP_SP    = 5'd26;
    localparam logic [OPW-1:0] OP_FIN   = 5'd27;

    typedef struct packed {
        logic [OPW-1:0] op;
        logic           load;   // query item accepted
        logic           wr;     // node write item accepted
    } crw_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic div_busy;
        logic has_m;
        logic has_p;
        logic out_full;
    } crw_stat_t;

endpackage

// ===== rtl/catmull_rom_weights_core.sv =====
// Top level of the non-uniform Catmull-Rom weight block: ports, field packing.
// Depends on crw_pkg, crw_ctrl and crw_datapath.
//
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   node_index, node_value, query_x             action
// m_axis    out  base_offset, weight0, weight1, weight2,      in_range
//                weight3
// cfg       in   cfg_wdata = node_count                      -
//
// A write item is written into the table as it is accepted. A query runs through accept,
// search, table reads and weight steps (s <= ceil(log2(n+1)) search steps), plus
// passes of the shared divider (FRAC_BITS+34 quotient bits): one pass for t and one
// per neighbor that is not folded in.
// Reset clears the controller, the divider and node_count (64); table contents
// stay undefined until written. The output register holds one result; a query
// finishing while it is still full waits, and items are taken only between queries.
`timescale 1ns / 1ps

module catmull_rom_weights_core #(
    parameter int MAX_NODES = crw_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = crw_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [crw_pkg::NCW-1:0]               cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // node_index[5:0], node_value[37:6], query_x[69:38], zero pad
    input  logic [crw_pkg::IN_TDATA_W-1:0]        s_tdata,
    // action[0]
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // base_offset, weight0, weight1, weight2, weight3, zero pad
    output logic [((7+4*(FRAC_BITS+4)+7)/8)*8-1:0] m_tdata,
    // in_range[0]
    output logic [0:0]                            m_tuser
);

    import crw_pkg::*;

    localparam int WW  = FRAC_BITS + 4;
    localparam int ODW = ((OFSW + 4*WW + 7) / 8) * 8;

    crw_cmd_t            cmd;
    crw_stat_t           stat;
    logic                out_in_range;
    logic [OFSW-1:0]     out_base;
    logic [3:0][WW-1:0]  out_w;

    crw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_query (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    crw_datapath #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .node_index   (s_tdata[IDXW-1:0]),
        .node_value   (signed'(s_tdata[IDXW+NODEW-1:IDXW])),
        .query_x      (signed'(s_tdata[IDXW+2*NODEW-1:IDXW+NODEW])),
        .out_take     (m_tvalid && m_tready),
        .out_valid    (m_tvalid),
        .out_in_range (out_in_range),
        .out_base     (out_base),
        .out_w        (out_w)
    );

    assign m_tdata = ODW'({out_w[3], out_w[2], out_w[1], out_w[0], out_base});
    assign m_tuser = out_in_range;

endmodule

// ===== rtl/crw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/crw_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module crw_div #(
    parameter int NUMW = 50,
    parameter int DENW = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            busy,
    output logic [NUMW-1:0] quot
);

    localparam int CNTW = $clog2(NUMW + 1);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [NUMW-1:0] quo_reg, quo_next;
    logic [DENW-1:0] den_reg, den_next;
    logic [DENW:0]   trial;
    logic [DENW:0]   diff;
    logic            ge;

    assign trial = {rem_reg, quo_reg[NUMW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(NUMW);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DENW-1:0] : trial[DENW-1:0];
            quo_next = {quo_reg[NUMW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule

// ===== rtl/crw_datapath.sv =====
// Datapath: node table, search registers, Hermite bases, weights and output register.
// Depends on crw_pkg, crw_ram and crw_div.
`timescale 1ns / 1ps

module crw_datapath #(
    parameter int MAX_NODES = crw_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = crw_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  crw_pkg::crw_cmd_t                  cmd,
    output crw_pkg::crw_stat_t                 stat,
    input  logic                               cfg_we,
    input  logic [crw_pkg::NCW-1:0]            cfg_wdata,
    input  logic [crw_pkg::IDXW-1:0]           node_index,
    input  logic signed [crw_pkg::NODEW-1:0]   node_value,
    input  logic signed [crw_pkg::NODEW-1:0]   query_x,
    input  logic                               out_take,
    output logic                               out_valid,
    output logic                               out_in_range,
    output logic [crw_pkg::OFSW-1:0]           out_base,
    output logic [3:0][FRAC_BITS+3:0]          out_w
);

    import crw_pkg::*;

    localparam int AW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int EW   = (CW > NCW) ? CW : NCW;
    localparam int WW   = FRAC_BITS + 4;
    localparam int TW   = FRAC_BITS + 1;
    localparam int HW   = FRAC_BITS + 4;
    localparam int NUMW = FRAC_BITS + 34;
    localparam int SW   = FRAC_BITS + 37;

    localparam logic [NUMW-1:0]      ONE_Q = NUMW'(1) << FRAC_BITS;
    localparam logic [TW-1:0]        ONE_T = TW'(1) << FRAC_BITS;
    localparam logic signed [HW-1:0] ONE_H = HW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] W_MAX = {{(SW-WW+1){1'b0}}, {(WW-1){1'b1}}};
    localparam logic signed [SW-1:0] W_MIN = {{(SW-WW+1){1'b1}}, {(WW-1){1'b0}}};

    function automatic logic [WW-1:0] sat_w(input logic signed [SW-1:0] v);
        logic [WW-1:0] r;
        if (v > W_MAX)
        begin
            r = W_MAX[WW-1:0];
        end
        else if (v < W_MIN)
        begin
            r = W_MIN[WW-1:0];
        end
        else
        begin
            r = v[WW-1:0];
        end
        return r;
    endfunction

    logic [NCW-1:0]           node_count_reg;
    logic                     out_valid_reg;
    logic                     out_in_range_reg;
    logic [OFSW-1:0]          out_base_reg;
    logic [3:0][WW-1:0]       out_w_reg;

    logic signed [NODEW-1:0]  x_reg, lo_reg, x0_reg, x1_reg, xm_reg, xp_reg;
    logic [CW-1:0]            n_reg, first_reg, len_reg, mid_reg, idx_reg;
    logic                     bad_reg, has_m_reg, has_p_reg, neg_reg;
    logic signed [NODEW:0]    dx_reg, denm_reg, denp_reg;
    logic [TW-1:0]            t_reg, t2_reg, t3_reg;
    logic signed [HW-1:0]     h00_reg, h01_reg, h10_reg, h11_reg;
    logic [NUMW-1:0]          prod_reg;
    logic signed [NUMW:0]     sm_reg, sp_reg;

    logic [NODEW-1:0]         ram_rdata;
    logic signed [NODEW-1:0]  rd_s;
    logic [AW-1:0]            ram_raddr;
    logic                     ram_we;
    logic [CW-1:0]            n_used, half_c, mid_c, idx_c;
    logic [EW-1:0]            nc_e;
    logic signed [NODEW:0]    xdiff, dx_c, denm_c, denp_c;
    logic                     div_start, div_busy;
    logic [NUMW-1:0]          div_num, div_quot;
    logic [NODEW-1:0]         div_den;
    logic [2*TW-1:0]          sq_c, cu_c;
    logic signed [HW-1:0]     t_s, t2_s, t3_s, habs_src;
    logic [HW-1:0]            habs;
    logic [HW+NODEW-1:0]      prod_c;
    logic signed [SW-1:0]     w0_c, w1_c, w2_c, w3_c;

    assign rd_s = signed'(ram_rdata);

    always_comb
    begin
        nc_e = EW'(node_count_reg);
        if (nc_e < EW'(2))
        begin
            n_used = CW'(2);
        end
        else if (nc_e > EW'(MAX_NODES))
        begin
            n_used = CW'(MAX_NODES);
        end
        else
        begin
            n_used = CW'(nc_e);
        end
    end

    assign half_c = len_reg >> 1;
    assign mid_c  = first_reg + half_c;

    always_comb
    begin
        idx_c = (first_reg == '0) ? '0 : first_reg - CW'(1);
        if (idx_c > n_reg - CW'(2))
        begin
            idx_c = n_reg - CW'(2);
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_RD_HI: ram_raddr = AW'(n_reg - CW'(1));
            OP_SRD:   ram_raddr = AW'(mid_c);
            OP_RX0:   ram_raddr = AW'(idx_reg);
            OP_RX1:   ram_raddr = AW'(idx_reg + CW'(1));
            OP_RXM:   ram_raddr = has_m_reg ? AW'(idx_reg - CW'(1)) : AW'(idx_reg);
            OP_RXP:   ram_raddr = has_p_reg ? AW'(idx_reg + CW'(2)) : AW'(idx_reg);
            default:  ram_raddr = '0;
        endcase
    end

    // Drop writes beyond the table.
    assign ram_we = cmd.wr && (int'(node_index) < MAX_NODES);

    crw_ram #(
        .WIDTH (NODEW),
        .DEPTH (MAX_NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(node_index)),
        .wdata (node_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign xdiff  = (NODEW+1)'(x_reg) - (NODEW+1)'(x0_reg);
    assign dx_c   = (NODEW+1)'(x1_reg) - (NODEW+1)'(x0_reg);
    assign denm_c = (NODEW+1)'(x1_reg) - (NODEW+1)'(xm_reg);
    assign denp_c = (NODEW+1)'(xp_reg) - (NODEW+1)'(x0_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = dx_reg[NODEW-1:0];
        case (cmd.op)
            OP_TDIV:
            begin
                div_start = 1'b1;
                div_num   = (xdiff > 0) ? (NUMW'($unsigned(xdiff)) << FRAC_BITS) : '0;
            end
            OP_DIVM:
            begin
                div_start = 1'b1;
                div_den   = denm_reg[NODEW-1:0];
            end
            OP_DIVP:
            begin
                div_start = 1'b1;
                div_den   = denp_reg[NODEW-1:0];
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    crw_div #(
        .NUMW (NUMW),
        .DENW (NODEW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign sq_c = (2*TW)'(t_reg) * (2*TW)'(t_reg);
    assign cu_c = (2*TW)'(t2_reg) * (2*TW)'(t_reg);
    assign t_s  = signed'(HW'(t_reg));
    assign t2_s = signed'(HW'(t2_reg));
    assign t3_s = signed'(HW'(t3_reg));

    assign habs_src = (cmd.op == OP_MULM) ? h10_reg : h11_reg;
    assign habs     = habs_src[HW-1] ? HW'(-habs_src) : HW'(habs_src);
    assign prod_c   = (HW+NODEW)'(habs) * (HW+NODEW)'(dx_reg[NODEW-1:0]);

    // End intervals fold the missing neighbor into the two inner weights.
    always_comb
    begin
        w0_c = has_m_reg ? -SW'(sm_reg) : '0;
        w1_c = SW'(h00_reg) - (has_m_reg ? SW'(0) : SW'(h10_reg))
                            - (has_p_reg ? SW'(sp_reg) : SW'(h11_reg));
        w2_c = SW'(h01_reg) + (has_m_reg ? SW'(sm_reg) : SW'(h10_reg))
                            + (has_p_reg ? SW'(0) : SW'(h11_reg));
        w3_c = has_p_reg ? SW'(sp_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.op == OP_FIN && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= query_x;
            n_reg <= n_used;
        end
        case (cmd.op)
            OP_RD_HI:
            begin
                lo_reg <= rd_s;
            end
            OP_CHK:
            begin
                bad_reg   <= !(x_reg >= lo_reg && x_reg <= rd_s);
                first_reg <= '0;
                len_reg   <= n_reg;
            end
            OP_SRD:
            begin
                mid_reg <= mid_c;
            end
            OP_SUPD:
            begin
                if (rd_s <= x_reg)
                begin
                    first_reg <= mid_reg + CW'(1);
                    len_reg   <= len_reg - half_c - CW'(1);
                end
                else
                begin
                    len_reg <= half_c;
                end
            end
            OP_IDX:
            begin
                idx_reg   <= idx_c;
                has_m_reg <= idx_c != '0;
                has_p_reg <= (idx_c + CW'(2)) < n_reg;
            end
            OP_RX1:
            begin
                x0_reg <= rd_s;
            end
            OP_RXM:
            begin
                x1_reg <= rd_s;
            end
            OP_RXP:
            begin
                xm_reg <= rd_s;
            end
            OP_CXP:
            begin
                xp_reg <= rd_s;
            end
            OP_DX:
            begin
                dx_reg   <= dx_c;
                denm_reg <= denm_c;
                denp_reg <= denp_c;
                bad_reg  <= bad_reg || (dx_c <= 0) || (has_m_reg && denm_c <= 0)
                            || (has_p_reg && denp_c <= 0);
            end
            OP_T:
            begin
                t_reg <= (div_quot > ONE_Q) ? ONE_T : TW'(div_quot);
            end
            OP_T2:
            begin
                t2_reg <= TW'(sq_c >> FRAC_BITS);
            end
            OP_T3:
            begin
                t3_reg <= TW'(cu_c >> FRAC_BITS);
            end
            OP_H:
            begin
                h00_reg <= (t3_s <<< 1) - (t2_s <<< 1) - t2_s + ONE_H;
                h01_reg <= (t2_s <<< 1) + t2_s - (t3_s <<< 1);
                h10_reg <= t3_s - (t2_s <<< 1) + t_s;
                h11_reg <= t3_s - t2_s;
            end
            OP_MULM, OP_MULP:
            begin
                prod_reg <= NUMW'(prod_c);
                neg_reg  <= habs_src[HW-1];
            end
            OP_SM:
            begin
                sm_reg <= neg_reg ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});
            end
            OP_SP:
            begin
                sp_reg <= neg_reg ? -signed'({1'b0, div_quot}) : signed'({1'b0, div_quot});
            end
            OP_FIN:
            begin
                if (!out_valid_reg)
                begin
                    out_in_range_reg <= !bad_reg;
                    out_base_reg     <= bad_reg ? '0 : OFSW'(idx_reg) - OFSW'(1);
                    out_w_reg[0]     <= bad_reg ? '0 : sat_w(w0_c);
                    out_w_reg[1]     <= bad_reg ? '0 : sat_w(w1_c);
                    out_w_reg[2]     <= bad_reg ? '0 : sat_w(w2_c);
                    out_w_reg[3]     <= bad_reg ? '0 : sat_w(w3_c);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.len_zero = len_reg == '0;
    assign stat.div_busy = div_busy;
    assign stat.has_m    = has_m_reg;
    assign stat.has_p    = has_p_reg;
    assign stat.out_full = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign out_in_range = out_in_range_reg;
    assign out_base     = out_base_reg;
    assign out_w        = out_w_reg;

endmodule

// ===== rtl/crw_ctrl.sv =====
// Controller: sequences one query through search, divisions and weight steps.
// Depends on crw_pkg.
`timescale 1ns / 1ps

module crw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_query,
    output logic               in_ready,
    input  crw_pkg::crw_stat_t stat,
    output crw_pkg::crw_cmd_t  cmd
);

    import crw_pkg::*;

    logic [OPW-1:0] state_reg, state_next;
    logic           accept;

    assign in_ready = state_reg == OP_IDLE;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            OP_IDLE:  if (accept && in_query) state_next = OP_RD_LO;
            OP_RD_LO: state_next = OP_RD_HI;
            OP_RD_HI: state_next = OP_CHK;
            OP_CHK:   state_next = OP_SRD;
            OP_SRD:   state_next = stat.len_zero ? OP_IDX : OP_SUPD;
            OP_SUPD:  state_next = OP_SRD;
            OP_IDX:   state_next = OP_RX0;
            OP_RX0:   state_next = OP_RX1;
            OP_RX1:   state_next = OP_RXM;
            OP_RXM:   state_next = OP_RXP;
            OP_RXP:   state_next = OP_CXP;
            OP_CXP:   state_next = OP_DX;
            OP_DX:    state_next = OP_TDIV;
            OP_TDIV:  state_next = OP_TWAIT;
            OP_TWAIT: if (!stat.div_busy) state_next = OP_T;
            OP_T:     state_next = OP_T2;
            OP_T2:    state_next = OP_T3;
            OP_T3:    state_next = OP_H;
            // Skip a neighbor division when that neighbor is folded in.
            OP_H:     state_next = stat.has_m ? OP_MULM : (stat.has_p ? OP_MULP : OP_FIN);
            OP_MULM:  state_next = OP_DIVM;
            OP_DIVM:  state_next = OP_MWAIT;
            OP_MWAIT: if (!stat.div_busy) state_next = OP_SM;
            OP_SM:    state_next = stat.has_p ? OP_MULP : OP_FIN;
            OP_MULP:  state_next = OP_DIVP;
            OP_DIVP:  state_next = OP_PWAIT;
            OP_PWAIT: if (!stat.div_busy) state_next = OP_SP;
            OP_SP:    state_next = OP_FIN;
            // Hold until the output register is free.
            OP_FIN:   if (!stat.out_full) state_next = OP_IDLE;
            default:  state_next = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= OP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.op   = state_reg;
    assign cmd.load = accept && in_query;
    assign cmd.wr   = accept && !in_query;

endmodule

// ===== rtl/crw_checker.sv =====
// Port-level checker for catmull_rom_weights_core, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module crw_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   cfg_we,
    input logic [6:0]                             cfg_wdata,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic [71:0]                            s_tdata,
    input logic [0:0]                             s_tuser,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((7+4*(FRAC_BITS+4)+7)/8)*8-1:0] m_tdata,
    input logic [0:0]                             m_tuser
);

    localparam int WW = FRAC_BITS + 4;

    // Stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Invalid results carry all-zero fields.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result with nonzero fields");

    // First interval folds the left neighbor: its weight is zero.
    a_left_fold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && m_tdata[6:0] == 7'h7F |-> m_tdata[7 +: WW] == '0)
        else $error("nonzero weight0 in first interval");

    // A query cannot finish in the cycle after it is taken.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind catmull_rom_weights_core crw_checker #(.FRAC_BITS(FRAC_BITS)) u_crw_checker (.*);
